FILE: rtl/smf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 16;
  localparam int CFG_BITS      = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int PC_BITS       = 4;

  // datapath widths: operand holds y1 + x - x1, product adds the coefficient
  localparam int OPND_BITS = SAMPLE_BITS + 2;
  localparam int PROD_BITS = OPND_BITS + COEF_BITS + 1;
  localparam int RND_BITS  = PROD_BITS - COEF_BITS;
  localparam int SUM_BITS  = RND_BITS + 1;

  // envelope follower coefficients, 0.01 and 0.1 in Q0.COEF_BITS
  localparam logic [COEF_BITS-1:0] ATTACK_Q  = COEF_BITS'(((1 << COEF_BITS) + 50) / 100);
  localparam logic [COEF_BITS-1:0] RELEASE_Q = COEF_BITS'(((1 << COEF_BITS) + 5) / 10);

  // register reset values
  localparam logic [COEF_BITS-1:0] HP_ALPHA_RST      = COEF_BITS'(63396);
  localparam logic [COEF_BITS-1:0] LP_ALPHA_RST      = COEF_BITS'(2086);
  localparam logic [COEF_BITS-1:0] BAND_HP_ALPHA_RST = COEF_BITS'(63449);
  localparam logic [COEF_BITS-1:0] BAND_LP_ALPHA_RST = COEF_BITS'(22966);

  typedef logic [COEF_BITS-1:0] coef_t;
  typedef logic [PC_BITS-1:0]   pc_t;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_MODEL_READY   = 3'd0,
    REG_STEM_MODE     = 3'd1,
    REG_HP_ALPHA      = 3'd2,
    REG_LP_ALPHA      = 3'd3,
    REG_BAND_HP_ALPHA = 3'd4,
    REG_BAND_LP_ALPHA = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_HIGHPASS  = 2'd0,
    MODE_TRANSIENT = 2'd1,
    MODE_LOWPASS   = 2'd2,
    MODE_BANDPASS  = 2'd3
  } stem_mode_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_HP,
    OP_ACC_HP,
    OP_MUL_LP,
    OP_ACC_LP,
    OP_MUL_ENV,
    OP_ACC_ENV,
    OP_TRANS,
    OP_EMIT,
    OP_PASS
  } alu_op_t;

  // coefficient select
  typedef enum logic [2:0] {
    CS_HP,
    CS_LP,
    CS_BAND_HP,
    CS_BAND_LP,
    CS_ENV
  } coef_sel_t;

  // sequencer next-step kinds
  typedef enum logic [2:0] {
    J_SEQ,
    J_GOTO,
    J_NRDY,
    J_MODE,
    J_END
  } jmp_t;

  typedef struct packed {
    alu_op_t   op;
    coef_sel_t csel;
    jmp_t      jmp;
    pc_t       target;
  } ctrl_t;

  typedef struct packed {
    logic       ready;
    logic [1:0] mode;
    coef_t      hp_alpha;
    coef_t      lp_alpha;
    coef_t      band_hp_alpha;
    coef_t      band_lp_alpha;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          run_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          rejected;
  } out_item_t;

  // microprogram addresses
  localparam pc_t PC_CHECK    = 4'd0;
  localparam pc_t PC_DISPATCH = 4'd1;
  localparam pc_t PC_HP_MUL   = 4'd2;
  localparam pc_t PC_HP_ACC   = 4'd3;
  localparam pc_t PC_TR_MUL   = 4'd4;
  localparam pc_t PC_TR_ACC   = 4'd5;
  localparam pc_t PC_TR_OUT   = 4'd6;
  localparam pc_t PC_LP_MUL   = 4'd7;
  localparam pc_t PC_LP_ACC   = 4'd8;
  localparam pc_t PC_BP_HMUL  = 4'd9;
  localparam pc_t PC_BP_HACC  = 4'd10;
  localparam pc_t PC_BP_LMUL  = 4'd11;
  localparam pc_t PC_BP_LACC  = 4'd12;
  localparam pc_t PC_EMIT     = 4'd13;
  localparam pc_t PC_PASS     = 4'd14;

  localparam ctrl_t CTRL_IDLE = '{op: OP_NOP, csel: CS_HP, jmp: J_SEQ, target: PC_CHECK};

  // microprogram rom
  function automatic ctrl_t rom_word(input pc_t pc);
    ctrl_t w;
    begin
      case (pc)
        PC_CHECK:    w = '{op: OP_NOP,     csel: CS_HP,      jmp: J_NRDY, target: PC_PASS};
        PC_DISPATCH: w = '{op: OP_NOP,     csel: CS_HP,      jmp: J_MODE, target: PC_CHECK};
        PC_HP_MUL:   w = '{op: OP_MUL_HP,  csel: CS_HP,      jmp: J_SEQ,  target: PC_CHECK};
        PC_HP_ACC:   w = '{op: OP_ACC_HP,  csel: CS_HP,      jmp: J_GOTO, target: PC_EMIT};
        PC_TR_MUL:   w = '{op: OP_MUL_ENV, csel: CS_ENV,     jmp: J_SEQ,  target: PC_CHECK};
        PC_TR_ACC:   w = '{op: OP_ACC_ENV, csel: CS_ENV,     jmp: J_SEQ,  target: PC_CHECK};
        PC_TR_OUT:   w = '{op: OP_TRANS,   csel: CS_ENV,     jmp: J_GOTO, target: PC_EMIT};
        PC_LP_MUL:   w = '{op: OP_MUL_LP,  csel: CS_LP,      jmp: J_SEQ,  target: PC_CHECK};
        PC_LP_ACC:   w = '{op: OP_ACC_LP,  csel: CS_LP,      jmp: J_GOTO, target: PC_EMIT};
        PC_BP_HMUL:  w = '{op: OP_MUL_HP,  csel: CS_BAND_HP, jmp: J_SEQ,  target: PC_CHECK};
        PC_BP_HACC:  w = '{op: OP_ACC_HP,  csel: CS_BAND_HP, jmp: J_SEQ,  target: PC_CHECK};
        PC_BP_LMUL:  w = '{op: OP_MUL_LP,  csel: CS_BAND_LP, jmp: J_SEQ,  target: PC_CHECK};
        PC_BP_LACC:  w = '{op: OP_ACC_LP,  csel: CS_BAND_LP, jmp: J_SEQ,  target: PC_CHECK};
        PC_EMIT:     w = '{op: OP_EMIT,    csel: CS_HP,      jmp: J_END,  target: PC_CHECK};
        PC_PASS:     w = '{op: OP_PASS,    csel: CS_HP,      jmp: J_END,  target: PC_CHECK};
        default:     w = '{op: OP_PASS,    csel: CS_HP,      jmp: J_END,  target: PC_CHECK};
      endcase
      rom_word = w;
    end
  endfunction

  // entry point of each mode's routine
  function automatic pc_t mode_entry(input logic [1:0] mode);
    pc_t p;
    begin
      case (mode)
        MODE_HIGHPASS:  p = PC_HP_MUL;
        MODE_TRANSIENT: p = PC_TR_MUL;
        MODE_LOWPASS:   p = PC_LP_MUL;
        MODE_BANDPASS:  p = PC_BP_HMUL;
        default:        p = PC_HP_MUL;
      endcase
      mode_entry = p;
    end
  endfunction

  // saturate a wide sum to a sample
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [SUM_BITS-1:0] v
  );
    logic [SUM_BITS-SAMPLE_BITS:0] top;
    begin
      top = v[SUM_BITS-1:SAMPLE_BITS-1];
      if (top == '0 || top == '1) begin
        sat_smp = v[SAMPLE_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
        sat_smp = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        sat_smp = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/smf_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module smf_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire smf_pkg::cfg_t  cfg,
  input  wire logic           out_free,
  output smf_pkg::ctrl_t      ctrl,
  output logic                busy,
  output logic                fire
);

  smf_pkg::pc_t pc_r, pc_nxt;
  logic         busy_r, busy_nxt;

  // control word of the current step
  assign ctrl = busy_r ? smf_pkg::rom_word(pc_r) : smf_pkg::CTRL_IDLE;
  assign busy = busy_r;
  assign fire = busy_r && (ctrl.jmp == smf_pkg::J_END) && out_free;

  // step counter and jumps
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = smf_pkg::PC_CHECK;
      end
    end else begin
      case (ctrl.jmp)
        smf_pkg::J_SEQ:  pc_nxt = pc_r + smf_pkg::pc_t'(1);
        smf_pkg::J_GOTO: pc_nxt = ctrl.target;
        smf_pkg::J_NRDY: pc_nxt = cfg.ready ? pc_r + smf_pkg::pc_t'(1) : ctrl.target;
        smf_pkg::J_MODE: pc_nxt = smf_pkg::mode_entry(cfg.mode);
        smf_pkg::J_END: begin
          if (out_free) begin
            busy_nxt = 1'b0;
          end
        end
        default: pc_nxt = pc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= smf_pkg::PC_CHECK;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/smf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module smf_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire smf_pkg::in_item_t  in_item,
  input  wire smf_pkg::ctrl_t     ctrl,
  input  wire smf_pkg::cfg_t      cfg,
  output smf_pkg::out_item_t      res
);

  localparam int SB = smf_pkg::SAMPLE_BITS;
  localparam int CB = smf_pkg::COEF_BITS;
  localparam int OW = smf_pkg::OPND_BITS;
  localparam int PW = smf_pkg::PROD_BITS;
  localparam int RW = smf_pkg::RND_BITS;
  localparam int SW = smf_pkg::SUM_BITS;
  localparam int DW = SB + 1;
  localparam logic signed [PW-1:0] RND_HALF = {{(PW-CB){1'b0}}, 1'b1, {(CB-1){1'b0}}};

  // working sample registers
  logic signed [SB-1:0] x_r;
  logic signed [SB-1:0] w_r;
  logic signed [PW-1:0] prod_r;

  // filter state
  logic signed [SB-1:0] prev_in_r;
  logic signed [SB-1:0] prev_hp_r;
  logic signed [SB-1:0] lp_r;
  logic        [SB-2:0] env_r;

  logic        [SB-2:0] mag;
  logic signed [SB-1:0] neg_x;
  logic signed [OW-1:0] opnd;
  smf_pkg::coef_t       coef;
  logic signed [CB:0]   coef_s;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] rnd_full;
  logic signed [RW-1:0] rnd;
  logic signed [SB-1:0] base;
  logic signed [SW-1:0] acc_sum;
  logic signed [SB-1:0] acc_y;
  logic signed [DW-1:0] tr_diff;
  logic signed [DW-1:0] tr_half;
  logic signed [SW-1:0] tr_sum;
  logic signed [SB-1:0] tr_y;

  // saturating magnitude of the sample
  always_comb begin
    neg_x = -x_r;
    if (!x_r[SB-1]) begin
      mag = x_r[SB-2:0];
    end else if (x_r == {1'b1, {(SB-1){1'b0}}}) begin
      mag = '1;
    end else begin
      mag = neg_x[SB-2:0];
    end
  end

  // multiplier operand
  always_comb begin
    case (ctrl.op)
      smf_pkg::OP_MUL_HP:  opnd = OW'(prev_hp_r) + OW'(x_r) - OW'(prev_in_r);
      smf_pkg::OP_MUL_LP:  opnd = OW'(w_r) - OW'(lp_r);
      smf_pkg::OP_MUL_ENV: opnd = OW'($signed({1'b0, mag})) - OW'($signed({1'b0, env_r}));
      default:             opnd = '0;
    endcase
  end

  // coefficient select
  always_comb begin
    case (ctrl.csel)
      smf_pkg::CS_HP:      coef = cfg.hp_alpha;
      smf_pkg::CS_LP:      coef = cfg.lp_alpha;
      smf_pkg::CS_BAND_HP: coef = cfg.band_hp_alpha;
      smf_pkg::CS_BAND_LP: coef = cfg.band_lp_alpha;
      smf_pkg::CS_ENV:     coef = (mag > env_r) ? smf_pkg::ATTACK_Q : smf_pkg::RELEASE_Q;
      default:             coef = '0;
    endcase
  end

  assign coef_s   = $signed({1'b0, coef});
  assign prod_nxt = PW'(opnd) * PW'(coef_s);

  // round half up, then add the accumulate base
  assign rnd_full = prod_r + RND_HALF;
  assign rnd      = $signed(rnd_full[PW-1:CB]);

  always_comb begin
    case (ctrl.op)
      smf_pkg::OP_ACC_LP:  base = lp_r;
      smf_pkg::OP_ACC_ENV: base = $signed({1'b0, env_r});
      default:             base = '0;
    endcase
  end

  assign acc_sum = SW'(base) + SW'(rnd);
  assign acc_y   = smf_pkg::sat_smp(acc_sum);

  // transient output: x plus half the excess over the envelope
  assign tr_diff = DW'($signed({1'b0, mag})) - DW'($signed({1'b0, env_r})) + DW'(1);
  assign tr_half = tr_diff >>> 1;
  assign tr_sum  = SW'(x_r) + SW'(tr_half);
  assign tr_y    = smf_pkg::sat_smp(tr_sum);

  // filter state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_r <= '0;
      prev_hp_r <= '0;
      lp_r      <= '0;
      env_r     <= '0;
    end else if (start) begin
      if (in_item.run_start) begin
        prev_in_r <= '0;
        prev_hp_r <= '0;
        lp_r      <= '0;
        env_r     <= '0;
      end
    end else begin
      case (ctrl.op)
        smf_pkg::OP_ACC_HP: begin
          prev_in_r <= x_r;
          prev_hp_r <= acc_y;
        end
        smf_pkg::OP_ACC_LP: begin
          lp_r <= acc_y;
        end
        smf_pkg::OP_ACC_ENV: begin
          env_r <= acc_y[SB-1] ? '0 : acc_y[SB-2:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sample, working value and product registers
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= in_item.sample_in;
      w_r <= in_item.sample_in;
    end else begin
      case (ctrl.op)
        smf_pkg::OP_MUL_HP,
        smf_pkg::OP_MUL_LP,
        smf_pkg::OP_MUL_ENV: prod_r <= prod_nxt;
        smf_pkg::OP_ACC_HP,
        smf_pkg::OP_ACC_LP:  w_r <= acc_y;
        smf_pkg::OP_TRANS:   w_r <= tr_y;
        default: begin
        end
      endcase
    end
  end

  // result of the finishing step
  assign res.sample_out = (ctrl.op == smf_pkg::OP_PASS) ? x_r : w_r;
  assign res.rejected   = (ctrl.op == smf_pkg::OP_PASS);

endmodule

`default_nettype wire

FILE: rtl/stem_mode_one_pole_filter.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | in_item_t: sample_in, run_start
// out_    | output    | out_valid/out_stall | out_item_t: sample_out, rejected
// cfg_    | input     | cfg_we              | cfg_addr (register index), cfg_wdata
//
// A transaction runs through a microprogram on one shared multiplier; each
// coefficient multiply takes a product step and an accumulate step.
// Steps: check, then pass if not ready, else dispatch, the mode's multiply
// steps, an output step in transient mode, and emit; the next transaction
// is taken the cycle after the final step. Synchronous active-low reset resets
// configuration, clears filter state and handshake control. A stalled result
// holds the sequencer at its final step; the input stalls during a transaction.
`timescale 1ns / 1ps
`default_nettype none

module stem_mode_one_pole_filter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire smf_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output smf_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_we,
  input  wire logic [smf_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  wire logic [smf_pkg::CFG_BITS-1:0]        cfg_wdata
);

  smf_pkg::cfg_t      cfg_r;
  smf_pkg::ctrl_t     ctrl;
  smf_pkg::out_item_t res;
  smf_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               busy;
  logic               fire;
  logic               start;
  logic               out_free;

  assign start    = in_valid && !busy;
  assign in_stall = busy;
  assign out_free = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready         <= 1'b0;
      cfg_r.mode          <= smf_pkg::MODE_HIGHPASS;
      cfg_r.hp_alpha      <= smf_pkg::HP_ALPHA_RST;
      cfg_r.lp_alpha      <= smf_pkg::LP_ALPHA_RST;
      cfg_r.band_hp_alpha <= smf_pkg::BAND_HP_ALPHA_RST;
      cfg_r.band_lp_alpha <= smf_pkg::BAND_LP_ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        smf_pkg::REG_MODEL_READY:   cfg_r.ready         <= cfg_wdata[0];
        smf_pkg::REG_STEM_MODE:     cfg_r.mode          <= cfg_wdata[1:0];
        smf_pkg::REG_HP_ALPHA:      cfg_r.hp_alpha      <= cfg_wdata[smf_pkg::COEF_BITS-1:0];
        smf_pkg::REG_LP_ALPHA:      cfg_r.lp_alpha      <= cfg_wdata[smf_pkg::COEF_BITS-1:0];
        smf_pkg::REG_BAND_HP_ALPHA: cfg_r.band_hp_alpha <= cfg_wdata[smf_pkg::COEF_BITS-1:0];
        smf_pkg::REG_BAND_LP_ALPHA: cfg_r.band_lp_alpha <= cfg_wdata[smf_pkg::COEF_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // microprogram sequencer
  smf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg      (cfg_r),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy),
    .fire     (fire)
  );

  // filter datapath
  smf_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_data),
    .ctrl    (ctrl),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/smf_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module smf_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire smf_pkg::out_item_t  out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one transaction at a time: input stalls right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a result cannot rise out of the check step that follows an accept
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 !$rose(out_valid))
    else $error("result too early after accept");

  // reset empties both channels
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not idle after reset");

endmodule

bind stem_mode_one_pole_filter smf_chk u_smf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: bench/stem_mode_one_pole_filter_test.sv
`timescale 1ns / 1ps

module stem_mode_one_pole_filter_test;
  import smf_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CALM_TAIL    = 150;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam longint SMP_HI      = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_LO      = -SMP_HI - 1;
  localparam longint ENV_ATTACK  = ((longint'(1) <<< COEF_BITS) + 50) / 100;
  localparam longint ENV_RELEASE = ((longint'(1) <<< COEF_BITS) + 5) / 10;

  // directed script rows
  typedef enum logic [1:0] {
    ROW_REG,
    ROW_SMP,
    ROW_KNOWN
  } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    cfg_reg_t      reg_idx;
    logic [15:0]   reg_val;
    in_item_t      stim;
    out_item_t     known;
  } row_t;

  typedef struct packed {
    logic      on;
    out_item_t item;
  } pinned_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_BITS-1:0]      cfg_wdata = '0;

  stem_mode_one_pole_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // filter predictor: settings and state
  logic       ready_r = 1'b0;
  stem_mode_t mode_r = MODE_HIGHPASS;
  coef_t      hp_a = HP_ALPHA_RST;
  coef_t      lp_a = LP_ALPHA_RST;
  coef_t      bhp_a = BAND_HP_ALPHA_RST;
  coef_t      blp_a = BAND_LP_ALPHA_RST;
  longint     hp_x1 = 0;
  longint     hp_y1 = 0;
  longint     lp_y = 0;
  longint     env_lvl = 0;

  out_item_t  result_q [$];
  pinned_t    pinned_q [$];
  row_t       script [$];
  int         issued_cnt = 0;
  int         done_cnt = 0;
  int         miss_cnt = 0;
  bit         idle_on = 1'b0;
  int         hold_left = 0;

  function automatic longint clip_smp(longint v);
    if (v > SMP_HI) return SMP_HI;
    if (v < SMP_LO) return SMP_LO;
    return v;
  endfunction

  // coefficient product, rounded half up
  function automatic longint scale_q(longint v, longint c);
    return (v * c + (longint'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS;
  endfunction

  function automatic longint run_highpass(longint x, coef_t a);
    longint y;
    y = clip_smp(scale_q(hp_y1 + x - hp_x1, longint'(a)));
    hp_x1 = x;
    hp_y1 = y;
    return y;
  endfunction

  function automatic longint run_lowpass(longint x, coef_t a);
    lp_y = clip_smp(lp_y + scale_q(x - lp_y, longint'(a)));
    return lp_y;
  endfunction

  // envelope follower, then half the excess added back
  function automatic longint run_transient(longint x);
    longint mag;
    mag = (x < 0) ? -x : x;
    if (mag > SMP_HI) mag = SMP_HI;
    env_lvl = env_lvl + scale_q(mag - env_lvl, (mag > env_lvl) ? ENV_ATTACK : ENV_RELEASE);
    if (env_lvl < 0) env_lvl = 0;
    if (env_lvl > SMP_HI) env_lvl = SMP_HI;
    return clip_smp(x + ((mag - env_lvl + 1) >>> 1));
  endfunction

  function automatic out_item_t filter_step(in_item_t it);
    out_item_t r;
    longint    x;
    longint    y;
    x = longint'($signed(it.sample_in));
    if (it.run_start) begin
      hp_x1 = 0;
      hp_y1 = 0;
      lp_y = 0;
      env_lvl = 0;
    end
    if (!ready_r) begin
      r.sample_out = it.sample_in;
      r.rejected = 1'b1;
      return r;
    end
    case (mode_r)
      MODE_HIGHPASS:  y = run_highpass(x, hp_a);
      MODE_TRANSIENT: y = run_transient(x);
      MODE_LOWPASS:   y = run_lowpass(x, lp_a);
      default:        y = run_lowpass(run_highpass(x, bhp_a), blp_a);
    endcase
    r.sample_out = y[SAMPLE_BITS-1:0];
    r.rejected = 1'b0;
    return r;
  endfunction

  // script row builders
  function automatic row_t reg_row(cfg_reg_t idx, logic [15:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t smp_row(logic [SAMPLE_BITS-1:0] s, logic st);
    row_t r;
    r = '0;
    r.kind = ROW_SMP;
    r.stim.sample_in = s;
    r.stim.run_start = st;
    return r;
  endfunction

  function automatic row_t known_row(logic [SAMPLE_BITS-1:0] s, logic st,
                                     logic [SAMPLE_BITS-1:0] ys, logic yr);
    row_t r;
    r = smp_row(s, st);
    r.kind = ROW_KNOWN;
    r.known.sample_out = ys;
    r.known.rejected = yr;
    return r;
  endfunction

  // present one transaction, with an optional idle burst ahead of it
  task automatic feed_sample(in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    cfg_we <= 1'b0;
    do @(posedge clk); while (in_stall !== 1'b0);
    issued_cnt++;
  endtask

  // register write, only once every result is back
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (done_cnt != issued_cnt) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MODEL_READY:   ready_r = val[0];
      REG_STEM_MODE:     mode_r = stem_mode_t'(val[1:0]);
      REG_HP_ALPHA:      hp_a = val;
      REG_LP_ALPHA:      lp_a = val;
      REG_BAND_HP_ALPHA: bhp_a = val;
      REG_BAND_LP_ALPHA: blp_a = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 4095));
      3:       return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: random stall bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      hold_left = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // predict on each accepted input, check each accepted result
  always @(posedge clk) begin : watch
    out_item_t want;
    pinned_t   pin;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        done_cnt++;
        if (result_q.size() == 0) begin
          $error("result with none pending: sample_out %0d rejected %0b",
                 $signed(out_data.sample_out), out_data.rejected);
          miss_cnt++;
        end else begin
          want = result_q.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_data.sample_out));
            miss_cnt++;
          end
          if (out_data.rejected !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, out_data.rejected);
            miss_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = filter_step(in_data);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.on) want = pin.item;
        end
        result_q.push_back(want);
      end
    end
  end

  initial begin : stimulus
    in_item_t    it;
    pinned_t     pin;
    logic [15:0] w;
    int          random_sent;
    int          chunk;
    int          span;
    longint      walk;
    bit          fresh;

    // not ready, then every mode with extreme samples and coefficients
    script.push_back(known_row(S_MAX, 1'b0, S_MAX, 1'b1));
    script.push_back(known_row(S_MIN, 1'b1, S_MIN, 1'b1));
    script.push_back(known_row('0, 1'b0, '0, 1'b1));
    script.push_back(known_row('1, 1'b0, '1, 1'b1));
    script.push_back(reg_row(REG_MODEL_READY, 16'd1));
    script.push_back(smp_row(S_MAX, 1'b1));
    script.push_back(smp_row(S_MIN, 1'b0));
    script.push_back(smp_row(S_MIN, 1'b0));
    script.push_back(smp_row(S_MAX, 1'b0));
    script.push_back(reg_row(REG_HP_ALPHA, 16'h0000));
    script.push_back(known_row(24'd12345, 1'b0, '0, 1'b0));
    script.push_back(reg_row(REG_HP_ALPHA, 16'hFFFF));
    script.push_back(smp_row(S_MAX, 1'b1));
    script.push_back(smp_row(S_MIN, 1'b0));
    script.push_back(reg_row(REG_STEM_MODE, 16'hFFFD));
    script.push_back(known_row('0, 1'b1, '0, 1'b0));
    script.push_back(smp_row(S_MIN, 1'b0));
    script.push_back(smp_row(S_MAX, 1'b0));
    script.push_back(smp_row(24'd1, 1'b0));
    script.push_back(reg_row(REG_STEM_MODE, 16'(MODE_LOWPASS)));
    script.push_back(reg_row(REG_LP_ALPHA, 16'hFFFF));
    script.push_back(smp_row(S_MAX, 1'b1));
    script.push_back(smp_row(S_MIN, 1'b0));
    script.push_back(reg_row(REG_LP_ALPHA, 16'h0000));
    script.push_back(known_row(24'h400000, 1'b1, '0, 1'b0));
    script.push_back(reg_row(REG_STEM_MODE, 16'(MODE_BANDPASS)));
    script.push_back(reg_row(REG_BAND_HP_ALPHA, 16'hFFFF));
    script.push_back(reg_row(REG_BAND_LP_ALPHA, 16'hFFFF));
    script.push_back(smp_row(S_MAX, 1'b1));
    script.push_back(smp_row(S_MIN, 1'b0));
    script.push_back(smp_row('1, 1'b0));
    script.push_back(reg_row(REG_BAND_LP_ALPHA, 16'h0000));
    script.push_back(known_row(S_MAX, 1'b1, '0, 1'b0));
    // ready cleared by a write with the upper bits set, run start still clears state
    script.push_back(reg_row(REG_MODEL_READY, 16'hFFFE));
    script.push_back(known_row(-24'sd5, 1'b1, -24'sd5, 1'b1));
    script.push_back(reg_row(REG_MODEL_READY, 16'd1));
    script.push_back(smp_row(S_MIN, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    idle_on = 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        pin.on = (script[i].kind == ROW_KNOWN);
        pin.item = script[i].known;
        pinned_q.push_back(pin);
        feed_sample(script[i].stim);
      end
    end

    // random part: a fresh setting per phase, mostly smooth runs
    random_sent = 0;
    walk = 0;
    while (random_sent < RANDOM_ITEMS) begin
      idle_on = (random_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 4) != 0);
      w = 16'($urandom);
      w[0] = ($urandom_range(0, 6) != 0);
      write_reg(REG_MODEL_READY, w);
      write_reg(REG_STEM_MODE, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_HP_ALPHA, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_LP_ALPHA, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_BAND_HP_ALPHA, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_BAND_LP_ALPHA, pick_coef());
      fresh = ($urandom_range(0, 9) < 7);
      chunk = $urandom_range(20, 80);
      span = 1 << $urandom_range(4, 22);
      repeat (chunk) begin
        case ($urandom_range(0, 9))
          0, 1:    it.sample_in = SAMPLE_BITS'($urandom);
          2:       it.sample_in = SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
          3: begin
            case ($urandom_range(0, 4))
              0:       it.sample_in = S_MAX;
              1:       it.sample_in = S_MIN;
              2:       it.sample_in = '0;
              3:       it.sample_in = '1;
              default: it.sample_in = 24'd1;
            endcase
          end
          default: begin
            walk = clip_smp(walk + longint'($urandom_range(0, 2 * span)) - span);
            it.sample_in = walk[SAMPLE_BITS-1:0];
          end
        endcase
        it.run_start = fresh || ($urandom_range(0, 40) == 0);
        fresh = 1'b0;
        feed_sample(it);
        random_sent++;
      end
    end

    // drain
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (done_cnt != issued_cnt) @(posedge clk);
    repeat (20) @(posedge clk);
    if (miss_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
